@@ src/nsdf_pkg.sv @@
// Shared types and constants for the netstring deframer.
// Used by every module of the block; depends on nothing.
package nsdf_pkg;

  localparam int LEN_WIDTH = 24;
  localparam int MAXLEN_WIDTH = 24;
  localparam int NV_WIDTH = LEN_WIDTH + 4;
  localparam int CMP_WIDTH = (NV_WIDTH > MAXLEN_WIDTH) ? NV_WIDTH : MAXLEN_WIDTH;

  localparam int QDEPTH = 4;
  localparam int QPTR_WIDTH = $clog2(QDEPTH);
  localparam int QCNT_WIDTH = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [3:0] RADIX = 4'd10;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOCOLON = 3'd1;
  localparam logic [2:0] ST_BADDIGIT = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_NOCOMMA = 3'd4;
  localparam logic [2:0] ST_TOOLONG = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] payload_byte;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

@@ src/nsdf_front.sv @@
// Front part: accepts encoded bytes, parses length/payload/comma, emits results.
// Holds the max_length register. Depends on nsdf_pkg.
module nsdf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  nsdf_pkg::in_item_t           in_item,
  input  logic                         cfg_we,
  input  logic [nsdf_pkg::MAXLEN_WIDTH-1:0] cfg_data,
  output nsdf_pkg::res_t               res
);

  localparam logic [1:0] PH_LEN = 2'd0;
  localparam logic [1:0] PH_PAY = 2'd1;
  localparam logic [1:0] PH_COMMA = 2'd2;
  localparam logic [1:0] PH_DROP = 2'd3;

  logic [1:0]                         phase_r, phase_nxt;
  logic [nsdf_pkg::LEN_WIDTH-1:0]     len_r, len_nxt;
  logic [nsdf_pkg::LEN_WIDTH-1:0]     rem_r, rem_nxt;
  logic [2:0]                         err_r, err_nxt;
  logic [nsdf_pkg::MAXLEN_WIDTH-1:0]  maxlen_r;

  logic [7:0]                         b;
  logic                               last;
  logic                               is_digit;
  logic [3:0]                         digit;
  logic [nsdf_pkg::CMP_WIDTH-1:0]     nv;
  logic [nsdf_pkg::CMP_WIDTH-1:0]     cap;
  logic [nsdf_pkg::CMP_WIDTH-1:0]     lim_cfg;
  logic [nsdf_pkg::CMP_WIDTH-1:0]     limit;

  assign b = in_item.in_byte;
  assign last = in_item.end_of_string;
  assign is_digit = (b >= nsdf_pkg::CHAR_ZERO) && (b <= nsdf_pkg::CHAR_NINE);
  assign digit = 4'(b - nsdf_pkg::CHAR_ZERO);
  // acc * 10 as two shifted adds
  assign nv = (nsdf_pkg::CMP_WIDTH'(len_r) << 3) + (nsdf_pkg::CMP_WIDTH'(len_r) << 1)
            + nsdf_pkg::CMP_WIDTH'(digit);
  assign cap = (nsdf_pkg::CMP_WIDTH'(1) << nsdf_pkg::LEN_WIDTH) - nsdf_pkg::CMP_WIDTH'(1);
  assign lim_cfg = nsdf_pkg::CMP_WIDTH'(maxlen_r);
  assign limit = (lim_cfg < cap) ? lim_cfg : cap;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt = len_r;
    rem_nxt = rem_r;
    err_nxt = err_r;
    res.valid = 1'b0;
    res.item.out_kind = nsdf_pkg::KIND_VERDICT;
    res.item.payload_byte = 8'd0;
    res.item.status = nsdf_pkg::ST_OK;
    if (accept) begin
      case (phase_r)
        PH_LEN: begin
          if (b == nsdf_pkg::CHAR_COLON) begin
            if (last) begin
              res.valid = 1'b1;
              res.item.status = (err_r != nsdf_pkg::ST_OK) ? err_r : nsdf_pkg::ST_NOCOMMA;
            end else if (err_r != nsdf_pkg::ST_OK) begin
              phase_nxt = PH_DROP;
            end else if (len_r == '0) begin
              phase_nxt = PH_COMMA;
            end else begin
              rem_nxt = len_r;
              phase_nxt = PH_PAY;
            end
          end else begin
            if (err_r == nsdf_pkg::ST_OK) begin
              if (!is_digit) begin
                err_nxt = nsdf_pkg::ST_BADDIGIT;
              end else if (nv > limit) begin
                err_nxt = nsdf_pkg::ST_TOOLONG;
              end else begin
                len_nxt = nsdf_pkg::LEN_WIDTH'(nv);
              end
            end
            if (last) begin
              res.valid = 1'b1;
              res.item.status = nsdf_pkg::ST_NOCOLON;
            end
          end
        end
        PH_PAY: begin
          res.valid = 1'b1;
          if (last) begin
            res.item.status = (b == nsdf_pkg::CHAR_COMMA) ? nsdf_pkg::ST_MISMATCH
                                                         : nsdf_pkg::ST_NOCOMMA;
          end else begin
            res.item.out_kind = nsdf_pkg::KIND_PAYLOAD;
            res.item.payload_byte = b;
            rem_nxt = rem_r - nsdf_pkg::LEN_WIDTH'(1);
            if (rem_r == nsdf_pkg::LEN_WIDTH'(1)) begin
              phase_nxt = PH_COMMA;
            end
          end
        end
        PH_COMMA: begin
          if (last) begin
            res.valid = 1'b1;
            res.item.status = (b == nsdf_pkg::CHAR_COMMA) ? nsdf_pkg::ST_OK
                                                         : nsdf_pkg::ST_NOCOMMA;
          end else begin
            err_nxt = nsdf_pkg::ST_MISMATCH;
            phase_nxt = PH_DROP;
          end
        end
        default: begin
          if (last) begin
            res.valid = 1'b1;
            res.item.status = err_r;
          end
        end
      endcase
      // every verdict starts a fresh frame
      if (last) begin
        phase_nxt = PH_LEN;
        len_nxt = '0;
        rem_nxt = '0;
        err_nxt = nsdf_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      len_r <= '0;
      rem_r <= '0;
      err_r <= nsdf_pkg::ST_OK;
      maxlen_r <= '1;
    end else begin
      phase_r <= phase_nxt;
      len_r <= len_nxt;
      rem_r <= rem_nxt;
      err_r <= err_nxt;
      if (cfg_we) begin
        maxlen_r <= cfg_data;
      end
    end
  end

endmodule

@@ src/nsdf_queue.sv @@
// Short result queue between the parser and the output stage.
// Depends on nsdf_pkg.
module nsdf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  nsdf_pkg::out_item_t   wr_item,
  output logic                  full,
  input  logic                  rd_en,
  output logic                  rd_valid,
  output nsdf_pkg::out_item_t   rd_item
);

  nsdf_pkg::out_item_t                  slot_r [nsdf_pkg::QDEPTH];
  logic [nsdf_pkg::QPTR_WIDTH-1:0]      wptr_r, wptr_nxt;
  logic [nsdf_pkg::QPTR_WIDTH-1:0]      rptr_r, rptr_nxt;
  logic [nsdf_pkg::QCNT_WIDTH-1:0]      cnt_r, cnt_nxt;
  logic                                 do_wr;
  logic                                 do_rd;

  assign full = (cnt_r == nsdf_pkg::QCNT_WIDTH'(nsdf_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item = slot_r[rptr_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && rd_valid;

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + nsdf_pkg::QPTR_WIDTH'(1) : wptr_r;
    rptr_nxt = do_rd ? rptr_r + nsdf_pkg::QPTR_WIDTH'(1) : rptr_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + nsdf_pkg::QCNT_WIDTH'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - nsdf_pkg::QCNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= wr_item;
    end
  end

endmodule

@@ src/nsdf_back.sv @@
// Back part: output register that presents the oldest result to the consumer.
// Pulls from nsdf_queue. Depends on nsdf_pkg.
module nsdf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  nsdf_pkg::out_item_t  q_item,
  output logic                 q_take,
  output logic                 empty,
  input  logic                 pop,
  output nsdf_pkg::out_item_t  out_item
);

  logic                 vld_r, vld_nxt;
  nsdf_pkg::out_item_t  item_r;

  assign q_take = q_valid && (!vld_r || pop);
  assign vld_nxt = q_take ? 1'b1 : (pop ? 1'b0 : vld_r);
  assign empty = !vld_r;
  assign out_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      item_r <= q_item;
    end
  end

endmodule

@@ src/netstring_deframer_core.sv @@
// Netstring deframer top level: parser front, result queue, output register.
// Depends on nsdf_pkg, nsdf_front, nsdf_queue, nsdf_back.
//
// Takes one byte of an encoded netstring per cycle and returns zero or one
// result per byte: a payload byte, or a verdict on the byte flagged as last.
// An input item is accepted whenever full is low; full rises only when the
// four-entry result queue is full, so with pop held high the block runs at
// one item per cycle indefinitely. A result is written into the queue when
// its byte is accepted and is loaded from the queue into the output register
// once that register is empty or being popped. The max_length register is
// always writable (cfg_ready is tied high) and resets to 16777215.
module netstring_deframer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  nsdf_pkg::in_item_t                in_item,
  output logic                              empty,
  input  logic                              pop,
  output nsdf_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nsdf_pkg::MAXLEN_WIDTH-1:0] cfg_data
);

  nsdf_pkg::res_t       res;
  logic                 accept;
  logic                 q_valid;
  logic                 q_take;
  nsdf_pkg::out_item_t  q_item;

  assign accept = push && !full;
  assign cfg_ready = 1'b1;

  nsdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res      (res)
  );

  nsdf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res.valid),
    .wr_item  (res.item),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  nsdf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

@@ src/nsdf_checker.sv @@
// Port-level checks for netstring_deframer_core, attached with bind.
// Depends on nsdf_pkg.
module nsdf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 empty,
  input logic                 pop,
  input logic                 cfg_ready,
  input nsdf_pkg::out_item_t  out_item
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("output not empty after reset");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.out_kind == nsdf_pkg::KIND_PAYLOAD) |->
      out_item.status == nsdf_pkg::ST_OK)
    else $error("payload item carries a nonzero status");

  a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.out_kind == nsdf_pkg::KIND_VERDICT) |->
      (out_item.payload_byte == 8'd0 && out_item.status <= nsdf_pkg::ST_TOOLONG))
    else $error("verdict item has bad fields");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind netstring_deframer_core nsdf_checker u_nsdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .empty     (empty),
  .pop       (pop),
  .cfg_ready (cfg_ready),
  .out_item  (out_item)
);
